[rtl/adpcm_pkg.sv]
package adpcm_pkg;

   // format register codes
   localparam logic [1:0] FMT_IMA = 2'd0;
   localparam logic [1:0] FMT_DSP = 2'd1;
   localparam logic [1:0] FMT_NDS = 2'd2;
   localparam logic [1:0] FMT_OKI = 2'd3;

   // channel_mode register codes
   localparam logic [1:0] MODE_MONO   = 2'd0;
   localparam logic [1:0] MODE_NIBBLE = 2'd1;
   localparam logic [1:0] MODE_BLOCK  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FORMAT       = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_MODE = 2'd1;
   localparam logic [1:0] CSR_INTERLEAVE   = 2'd2;

   // last valid step index of each table
   localparam logic [6:0] IMA_LAST = 7'd88;
   localparam logic [6:0] OKI_LAST = 7'd48;

   localparam logic [14:0] IMA_STEPS [89] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   localparam logic [14:0] OKI_STEPS [49] = '{
      15'd256,   15'd272,   15'd304,   15'd336,   15'd368,   15'd400,   15'd448,
      15'd496,   15'd544,   15'd592,   15'd656,   15'd720,   15'd800,   15'd880,
      15'd960,   15'd1056,  15'd1168,  15'd1280,  15'd1408,  15'd1552,  15'd1712,
      15'd1888,  15'd2080,  15'd2288,  15'd2512,  15'd2768,  15'd3040,  15'd3344,
      15'd3680,  15'd4048,  15'd4464,  15'd4912,  15'd5392,  15'd5936,  15'd6528,
      15'd7184,  15'd7904,  15'd8704,  15'd9568,  15'd10528, 15'd11584, 15'd12736,
      15'd14016, 15'd15408, 15'd16960, 15'd18656, 15'd20512, 15'd22576, 15'd24832
   };

   // step index adjustment per code magnitude: -1 for small codes, 2,4,6,8 above
   function automatic logic signed [4:0] idx_adjust(input logic [2:0] code);
      logic signed [4:0] adj;
      if (code[2]) begin
         adj = signed'({2'b00, code[1:0], 1'b0}) + 5'sd2;
      end else begin
         adj = -5'sd1;
      end
      return adj;
   endfunction

   typedef enum logic [1:0] {
      JOB_DECODE,
      JOB_LOAD_PRED,
      JOB_LOAD_INDEX
   } adpcm_job_kind_type;

   typedef struct packed {
      logic [1:0]  format;
      logic [1:0]  channel_mode;
      logic [15:0] interleave_bytes;
   } adpcm_cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] range_length;
   } adpcm_req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel_id;
      logic               last_of_byte;
   } adpcm_rsp_type;

   typedef struct packed {
      adpcm_job_kind_type kind;
      logic               clear;
      logic [3:0]         nib0;
      logic [3:0]         nib1;
      logic               ch0;
      logic               ch1;
      logic [15:0]        value;
   } adpcm_job_type;

endpackage

[rtl/adpcm_fifo.sv]
module adpcm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/adpcm_front.sv]
module adpcm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  adpcm_pkg::adpcm_cfg_type cfg,
   input  logic                     req_push,
   input  adpcm_pkg::adpcm_req_type req_data,
   output logic                     req_full,
   output logic                     job_push,
   output adpcm_pkg::adpcm_job_type job_data,
   input  logic                     job_full
);

   // header bytes still to come after the first one
   localparam logic [2:0] HDR_LEFT_START = 3'd3;
   localparam logic [2:0] HDR_LEFT_PRED  = 3'd3;
   localparam logic [2:0] HDR_LEFT_HIGH  = 3'd2;
   localparam logic [15:0] HDR_MIN_LEN   = 16'd4;

   logic        active_ff, active_in;
   logic [15:0] count_ff, count_in;
   logic [2:0]  left_ff, left_in;
   logic [7:0]  high_ff, high_in;

   logic        accept, oki, act_base;
   logic [15:0] count_base, count_next, word;
   logic [6:0]  index_clamped;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign oki      = (cfg.format == adpcm_pkg::FMT_OKI);
   assign word     = {high_ff, req_data.data_byte};

   // a range start resets the block position before the byte is routed
   assign act_base   = req_data.first_byte ? oki : active_ff;
   assign count_base = req_data.first_byte ? '0 : count_ff;
   assign count_next = count_base + 16'd1;

   // clamp the header step index word to the IMA table
   always_comb begin
      if (word[15]) begin
         index_clamped = '0;
      end else if (word > {9'd0, adpcm_pkg::IMA_LAST}) begin
         index_clamped = adpcm_pkg::IMA_LAST;
      end else begin
         index_clamped = word[6:0];
      end
   end

   // classify the beat: header capture, state load or nibble pair
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      high_in   = high_ff;
      job_push  = 1'b0;
      job_data  = '0;
      if (accept) begin
         if (req_data.first_byte) begin
            count_in  = '0;
            active_in = oki;
         end
         if (req_data.first_byte && cfg.format == adpcm_pkg::FMT_DSP &&
             req_data.range_length > HDR_MIN_LEN) begin
            high_in = req_data.data_byte;
            left_in = HDR_LEFT_START;
         end else if (!req_data.first_byte && left_ff != '0) begin
            left_in = left_ff - 3'd1;
            case (left_ff)
               HDR_LEFT_PRED: begin
                  job_push       = 1'b1;
                  job_data.kind  = adpcm_pkg::JOB_LOAD_PRED;
                  job_data.value = word;
               end
               HDR_LEFT_HIGH: begin
                  high_in = req_data.data_byte;
               end
               default: begin
                  job_push       = 1'b1;
                  job_data.kind  = adpcm_pkg::JOB_LOAD_INDEX;
                  job_data.value = {9'd0, index_clamped};
               end
            endcase
         end else begin
            left_in        = '0;
            job_push       = 1'b1;
            job_data.kind  = adpcm_pkg::JOB_DECODE;
            job_data.clear = req_data.first_byte;
            job_data.nib0  = oki ? req_data.data_byte[7:4] : req_data.data_byte[3:0];
            job_data.nib1  = oki ? req_data.data_byte[3:0] : req_data.data_byte[7:4];
            case (cfg.channel_mode)
               adpcm_pkg::MODE_NIBBLE: begin
                  job_data.ch0 = oki;
                  job_data.ch1 = !oki;
               end
               adpcm_pkg::MODE_BLOCK: begin
                  job_data.ch0 = act_base;
                  job_data.ch1 = act_base;
                  if (count_next >= cfg.interleave_bytes) begin
                     count_in  = '0;
                     active_in = !act_base;
                  end else begin
                     count_in  = count_next;
                     active_in = act_base;
                  end
               end
               default: begin
                  job_data.ch0 = 1'b0;
                  job_data.ch1 = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         left_ff   <= '0;
         high_ff   <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
         high_ff   <= high_in;
      end
   end

endmodule

[rtl/adpcm_back.sv]
module adpcm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  adpcm_pkg::adpcm_cfg_type cfg,
   input  logic                     job_empty,
   input  adpcm_pkg::adpcm_job_type job_data,
   output logic                     job_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output adpcm_pkg::adpcm_rsp_type rsp_wdata
);

   localparam logic signed [17:0] SUM_MAX     = 18'sd32767;
   localparam logic signed [17:0] SUM_MIN     = -18'sd32768;
   localparam logic signed [17:0] SUM_MIN_SYM = -18'sd32767;

   logic signed [15:0] pred_ff [2];
   logic signed [15:0] pred_in [2];
   logic [6:0]         idx_ff [2];
   logic [6:0]         idx_in [2];
   logic               phase_ff, phase_in;

   logic               oki, sym_clamp, zero_state, ch;
   logic [3:0]         nib;
   logic signed [15:0] pred_cur;
   logic [6:0]         idx_cur, idx_sat, last, idx_new;
   logic [14:0]        step;
   logic [16:0]        mag;
   logic signed [17:0] mag_s, sum, sum_clamped;
   logic signed [8:0]  idx_sum;

   assign oki        = (cfg.format == adpcm_pkg::FMT_OKI);
   assign sym_clamp  = (cfg.format == adpcm_pkg::FMT_DSP) ||
                       (cfg.format == adpcm_pkg::FMT_NDS);
   assign last       = oki ? adpcm_pkg::OKI_LAST : adpcm_pkg::IMA_LAST;
   assign nib        = phase_ff ? job_data.nib1 : job_data.nib0;
   assign ch         = phase_ff ? job_data.ch1 : job_data.ch0;
   assign zero_state = !phase_ff && job_data.clear;
   assign pred_cur   = zero_state ? '0 : pred_ff[ch];
   assign idx_cur    = zero_state ? '0 : idx_ff[ch];
   assign idx_sat    = (idx_cur > last) ? last : idx_cur;

   // look up the step size and build the delta magnitude
   always_comb begin
      step = oki ? adpcm_pkg::OKI_STEPS[idx_sat[5:0]] : adpcm_pkg::IMA_STEPS[idx_sat];
      mag  = {5'd0, step[14:3]};
      if (nib[2]) begin
         mag = mag + {2'd0, step};
      end
      if (nib[1]) begin
         mag = mag + {3'd0, step[14:1]};
      end
      if (nib[0]) begin
         mag = mag + {4'd0, step[14:2]};
      end
      mag_s = signed'({1'b0, mag});
   end

   // add to the predictor and clamp per format
   always_comb begin
      sum         = 18'(pred_cur) + (nib[3] ? -mag_s : mag_s);
      sum_clamped = sum;
      if (sym_clamp) begin
         if (sum != SUM_MIN) begin
            if (sum > SUM_MAX) begin
               sum_clamped = SUM_MAX;
            end else if (sum < SUM_MIN_SYM) begin
               sum_clamped = SUM_MIN_SYM;
            end
         end
      end else begin
         if (sum > SUM_MAX) begin
            sum_clamped = SUM_MAX;
         end else if (sum < SUM_MIN) begin
            sum_clamped = SUM_MIN;
         end
      end
   end

   // move the step index and clamp it to the table
   always_comb begin
      idx_sum = signed'({2'b00, idx_sat}) + 9'(adpcm_pkg::idx_adjust(nib[2:0]));
      if (idx_sum < 0) begin
         idx_new = '0;
      end else if (idx_sum > signed'({2'b00, last})) begin
         idx_new = last;
      end else begin
         idx_new = idx_sum[6:0];
      end
   end

   assign rsp_wdata.sample       = sum_clamped[15:0];
   assign rsp_wdata.channel_id   = ch;
   assign rsp_wdata.last_of_byte = phase_ff;

   // carry out the head job: one nibble per beat, loads without waiting on the result queue
   always_comb begin
      pred_in  = pred_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      if (!job_empty) begin
         case (job_data.kind)
            adpcm_pkg::JOB_LOAD_PRED: begin
               job_pop    = 1'b1;
               pred_in[0] = job_data.value;
            end
            adpcm_pkg::JOB_LOAD_INDEX: begin
               job_pop   = 1'b1;
               idx_in[0] = job_data.value[6:0];
            end
            adpcm_pkg::JOB_DECODE: begin
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  job_pop  = phase_ff;
                  phase_in = !phase_ff;
                  if (zero_state) begin
                     pred_in[!ch] = '0;
                     idx_in[!ch]  = '0;
                  end
                  pred_in[ch] = sum_clamped[15:0];
                  idx_in[ch]  = idx_new;
               end
            end
            default: begin
               job_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff[0] <= '0;
         pred_ff[1] <= '0;
         idx_ff[0]  <= '0;
         idx_ff[1]  <= '0;
         phase_ff   <= 1'b0;
      end else begin
         pred_ff  <= pred_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/adpcm_nibble_decoder_top.sv]
// Channel  Ports                               Beat taken when
// req      req_push, req_full, req_data        req_push && !req_full
// rsp      rsp_empty, rsp_pop, rsp_data        rsp_pop && !rsp_empty
// csr      csr_we, csr_addr, csr_wdata         csr_we
//
// In the back end a data byte is decoded one nibble at a time, each through the
// step table lookup, delta add and clamp; a header byte gives one load job or none.
// The front end takes a byte every cycle while the job queue has room.
// Reset is synchronous: it clears predictors, indices, routing state, the
// configuration registers and both queues at once.
// A stalled rsp side fills the result queue, then the job queue, then raises
// req_full; nothing is dropped.
module adpcm_nibble_decoder_top #(
   parameter int JOB_DEPTH = 2,
   parameter int RSP_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  adpcm_pkg::adpcm_req_type req_data,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output adpcm_pkg::adpcm_rsp_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_addr,
   input  logic [15:0]              csr_wdata
);

   localparam int JOB_W = $bits(adpcm_pkg::adpcm_job_type);
   localparam int RSP_W = $bits(adpcm_pkg::adpcm_rsp_type);

   adpcm_pkg::adpcm_cfg_type cfg_ff, cfg_in;
   adpcm_pkg::adpcm_job_type job_wdata, job_rdata;
   adpcm_pkg::adpcm_rsp_type rsp_wdata;
   logic                     job_push, job_full, job_pop, job_empty;
   logic                     rsp_push, rsp_full;
   logic [JOB_W-1:0]         job_rbits;
   logic [RSP_W-1:0]         rsp_rbits;

   // write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            adpcm_pkg::CSR_FORMAT:       cfg_in.format           = csr_wdata[1:0];
            adpcm_pkg::CSR_CHANNEL_MODE: cfg_in.channel_mode     = csr_wdata[1:0];
            adpcm_pkg::CSR_INTERLEAVE:   cfg_in.interleave_bytes = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format           <= adpcm_pkg::FMT_IMA;
         cfg_ff.channel_mode     <= adpcm_pkg::MODE_MONO;
         cfg_ff.interleave_bytes <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adpcm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_push (job_push),
      .job_data (job_wdata),
      .job_full (job_full)
   );

   adpcm_fifo #(.WIDTH(JOB_W), .DEPTH(JOB_DEPTH)) u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wdata),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rbits),
      .empty (job_empty)
   );

   assign job_rdata = adpcm_pkg::adpcm_job_type'(job_rbits);

   adpcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_rdata),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_wdata (rsp_wdata)
   );

   adpcm_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rbits),
      .empty (rsp_empty)
   );

   assign rsp_data = adpcm_pkg::adpcm_rsp_type'(rsp_rbits);

endmodule

[rtl/adpcm_checker.sv]
module adpcm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input adpcm_pkg::adpcm_rsp_type rsp_data
);

   // reset leaves the result queue empty and the job queue not full
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled result changed");

   // the first sample of a byte is followed by its second
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_data.last_of_byte |=>
         rsp_empty || rsp_data.last_of_byte)
      else $error("first sample not followed by second");

   // a byte's second sample is followed by a new byte's first
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && rsp_data.last_of_byte |=>
         rsp_empty || !rsp_data.last_of_byte)
      else $error("second sample not followed by first");

endmodule

bind adpcm_nibble_decoder_top adpcm_checker u_checker (.*);
